// ----- hw/rtl/keyword_lexer_unit_defines.svh -----
// keyword_lexer_unit_defines.svh: assertion macros shared by the lexer RTL.
// Depends on signals named clk and arst_n in the including module.
`ifndef KEYWORD_LEXER_UNIT_DEFINES_SVH
`define KEYWORD_LEXER_UNIT_DEFINES_SVH

// Property check, clocked on clk, off while reset is asserted
`define KL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold
`define KL_NEVER(label, expr, msg) \
	`KL_ASSERT(label, !(expr), msg)

`endif

// ----- hw/rtl/kl_pkg.sv -----
// kl_pkg: types, token codes and character constants for the keyword lexer.
// No dependencies.
`default_nettype none

package kl_pkg;

	// Scanner modes
	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_LOWER  = 3'd1,
		MODE_UPPER  = 3'd2,
		MODE_NUMBER = 3'd3,
		MODE_COLON  = 3'd4,
		MODE_HALTED = 3'd5
	} mode_t;

	// Token kinds
	localparam logic [4:0] KIND_IDENT  = 5'd0;
	localparam logic [4:0] KIND_INT    = 5'd1;
	localparam logic [4:0] KIND_IF     = 5'd2;
	localparam logic [4:0] KIND_THEN   = 5'd3;
	localparam logic [4:0] KIND_ELSE   = 5'd4;
	localparam logic [4:0] KIND_PLUS   = 5'd5;
	localparam logic [4:0] KIND_MINUS  = 5'd6;
	localparam logic [4:0] KIND_STAR   = 5'd7;
	localparam logic [4:0] KIND_SLASH  = 5'd8;
	localparam logic [4:0] KIND_LPAREN = 5'd9;
	localparam logic [4:0] KIND_RPAREN = 5'd10;
	localparam logic [4:0] KIND_COMMA  = 5'd11;
	localparam logic [4:0] KIND_SEMI   = 5'd12;
	localparam logic [4:0] KIND_COLON  = 5'd13;
	localparam logic [4:0] KIND_ASSIGN = 5'd14;
	localparam logic [4:0] KIND_EQUAL  = 5'd15;
	localparam logic [4:0] KIND_LBRACK = 5'd16;
	localparam logic [4:0] KIND_RBRACK = 5'd17;
	localparam logic [4:0] KIND_ERROR  = 5'd18;
	localparam logic [4:0] KIND_END    = 5'd19;
	localparam logic [4:0] KIND_NONE   = 5'd0;

	// Characters
	localparam logic [7:0] CHR_TAB    = 8'h09;
	localparam logic [7:0] CHR_LF     = 8'h0A;
	localparam logic [7:0] CHR_SPACE  = 8'h20;
	localparam logic [7:0] CHR_LPAREN = 8'h28;
	localparam logic [7:0] CHR_RPAREN = 8'h29;
	localparam logic [7:0] CHR_STAR   = 8'h2A;
	localparam logic [7:0] CHR_PLUS   = 8'h2B;
	localparam logic [7:0] CHR_COMMA  = 8'h2C;
	localparam logic [7:0] CHR_MINUS  = 8'h2D;
	localparam logic [7:0] CHR_SLASH  = 8'h2F;
	localparam logic [7:0] CHR_DIG_0  = 8'h30;
	localparam logic [7:0] CHR_DIG_9  = 8'h39;
	localparam logic [7:0] CHR_COLON  = 8'h3A;
	localparam logic [7:0] CHR_SEMI   = 8'h3B;
	localparam logic [7:0] CHR_EQUAL  = 8'h3D;
	localparam logic [7:0] CHR_UP_A   = 8'h41;
	localparam logic [7:0] CHR_UP_Z   = 8'h5A;
	localparam logic [7:0] CHR_LBRACK = 8'h5B;
	localparam logic [7:0] CHR_RBRACK = 8'h5D;
	localparam logic [7:0] CHR_LOW_A  = 8'h61;
	localparam logic [7:0] CHR_LOW_Z  = 8'h7A;

	// Keyword spellings, first character in the low byte
	localparam logic [63:0] KW_IF     = 64'h0000_0000_0000_4649;
	localparam logic [63:0] KW_THEN   = 64'h0000_0000_4E45_4854;
	localparam logic [63:0] KW_ELSE   = 64'h0000_0000_4553_4C45;
	localparam logic [63:0] TXT_ASSIGN = 64'h0000_0000_0000_3D3A;

	localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;
	localparam logic [3:0]  LEN_MAX   = 4'd15;

	// Request: one source character
	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} in_t;

	// Result: one token
	typedef struct packed {
		logic [4:0]  token_kind;
		logic [30:0] int_value;
		logic [63:0] text_bytes;
		logic [3:0]  text_length;
		logic        last_of_run;
	} out_t;

	// Tokens produced by one scan step, t0 first
	typedef struct packed {
		logic [1:0] n;
		out_t       t0;
		out_t       t1;
	} step_res_t;

	// Single-character symbol lookup; KIND_NONE when not a symbol
	function automatic logic [4:0] sym_kind(input logic [7:0] c);
		logic [4:0] k;
		k = KIND_NONE;
		case (c)
			CHR_PLUS:   k = KIND_PLUS;
			CHR_MINUS:  k = KIND_MINUS;
			CHR_STAR:   k = KIND_STAR;
			CHR_SLASH:  k = KIND_SLASH;
			CHR_LPAREN: k = KIND_LPAREN;
			CHR_RPAREN: k = KIND_RPAREN;
			CHR_COMMA:  k = KIND_COMMA;
			CHR_SEMI:   k = KIND_SEMI;
			CHR_EQUAL:  k = KIND_EQUAL;
			CHR_LBRACK: k = KIND_LBRACK;
			CHR_RBRACK: k = KIND_RBRACK;
			default:    k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/kl_step.sv -----
// kl_step: combinational scan step: next scanner state and up to two tokens.
// Depends on kl_pkg.
`default_nettype none

module kl_step import kl_pkg::*; #(
	parameter int TEXT_BYTES = 8
) (
	input  mode_t                     mode,
	input  logic [8*TEXT_BYTES-1:0]   wbuf,
	input  logic [3:0]                wlen,
	input  logic [30:0]               acc,
	input  logic [7:0]                char_code,
	input  logic                      end_of_input,
	output mode_t                     mode_nx,
	output logic [8*TEXT_BYTES-1:0]   wbuf_nx,
	output logic [3:0]                wlen_nx,
	output logic [30:0]               acc_nx,
	output step_res_t                 res
);

	localparam int BW = 8 * TEXT_BYTES;

	logic [7:0]    c;
	logic          is_low, is_up, is_dig, is_space;
	logic [4:0]    sym;
	logic [63:0]   wbuf_ext;
	out_t          pend_tok, idle_tok, end_tok, asg_tok;
	logic          pend_v, idle_v;
	mode_t         idle_mode;
	logic [BW-1:0] idle_wbuf, app_wbuf;
	logic [3:0]    idle_len, app_len;
	logic [30:0]   idle_acc, num_acc;
	logic [34:0]   acc_x10;
	out_t          tok_a, tok_b;
	logic          a_v, b_v;

	// Character classes
	assign c        = char_code;
	assign is_low   = (c >= CHR_LOW_A) && (c <= CHR_LOW_Z);
	assign is_up    = (c >= CHR_UP_A) && (c <= CHR_UP_Z);
	assign is_dig   = (c >= CHR_DIG_0) && (c <= CHR_DIG_9);
	assign is_space = (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_LF);
	assign sym      = sym_kind(c);
	assign wbuf_ext = 64'(wbuf);

	// Fixed tokens
	always_comb begin
		end_tok            = '0;
		end_tok.token_kind = KIND_END;
		asg_tok             = '0;
		asg_tok.token_kind  = KIND_ASSIGN;
		asg_tok.text_bytes  = TXT_ASSIGN;
		asg_tok.text_length = 4'd2;
	end

	// Token for whatever the scanner is holding
	always_comb begin
		pend_tok = '0;
		pend_v   = 1'b0;
		unique case (mode)
			MODE_LOWER: begin
				pend_v               = 1'b1;
				pend_tok.token_kind  = KIND_IDENT;
				pend_tok.text_bytes  = wbuf_ext;
				pend_tok.text_length = wlen;
			end
			MODE_UPPER: begin
				pend_v               = 1'b1;
				pend_tok.text_bytes  = wbuf_ext;
				pend_tok.text_length = wlen;
				if (wlen == 4'd2 && wbuf_ext == KW_IF) begin
					pend_tok.token_kind = KIND_IF;
				end else if (wlen == 4'd4 && wbuf_ext == KW_THEN) begin
					pend_tok.token_kind = KIND_THEN;
				end else if (wlen == 4'd4 && wbuf_ext == KW_ELSE) begin
					pend_tok.token_kind = KIND_ELSE;
				end else begin
					pend_tok.token_kind = KIND_IDENT;
				end
			end
			MODE_NUMBER: begin
				pend_v              = 1'b1;
				pend_tok.token_kind = KIND_INT;
				pend_tok.int_value  = acc;
			end
			MODE_COLON: begin
				pend_v               = 1'b1;
				pend_tok.token_kind  = KIND_COLON;
				pend_tok.text_bytes  = 64'(CHR_COLON);
				pend_tok.text_length = 4'd1;
			end
			default: begin
				pend_v = 1'b0;
			end
		endcase
	end

	// Character seen from a cleared idle scanner
	always_comb begin
		idle_v    = 1'b0;
		idle_tok  = '0;
		idle_mode = MODE_IDLE;
		idle_wbuf = '0;
		idle_len  = '0;
		idle_acc  = '0;
		if (is_space) begin
			idle_mode = MODE_IDLE;
		end else if (is_low) begin
			idle_mode = MODE_LOWER;
			idle_wbuf = BW'(c);
			idle_len  = 4'd1;
		end else if (is_up) begin
			idle_mode = MODE_UPPER;
			idle_wbuf = BW'(c);
			idle_len  = 4'd1;
		end else if (is_dig) begin
			idle_mode = MODE_NUMBER;
			idle_acc  = 31'(c - CHR_DIG_0);
		end else if (c == CHR_COLON) begin
			idle_mode = MODE_COLON;
		end else if (sym != KIND_NONE) begin
			idle_v               = 1'b1;
			idle_tok.token_kind  = sym;
			idle_tok.text_bytes  = 64'(c);
			idle_tok.text_length = 4'd1;
		end else begin
			idle_v              = 1'b1;
			idle_tok.token_kind = KIND_ERROR;
			idle_mode           = MODE_HALTED;
		end
	end

	// Word append: bytes past the buffer are dropped, length saturates
	always_comb begin
		app_wbuf = wbuf;
		for (int i = 0; i < TEXT_BYTES; i++) begin
			if (wlen == 4'(i)) begin
				app_wbuf[8*i +: 8] = c;
			end
		end
		app_len = (wlen == LEN_MAX) ? wlen : wlen + 4'd1;
	end

	// Decimal accumulate as acc*8 + acc*2 + digit, saturating
	assign acc_x10 = 35'({acc, 3'b000}) + 35'({acc, 1'b0}) + 35'(c - CHR_DIG_0);
	assign num_acc = (acc_x10 > 35'(INT_MAX31)) ? INT_MAX31 : acc_x10[30:0];

	// Next state and token selection
	always_comb begin
		logic restart;
		restart = 1'b0;
		mode_nx = mode;
		wbuf_nx = wbuf;
		wlen_nx = wlen;
		acc_nx  = acc;
		tok_a   = '0;
		tok_b   = '0;
		a_v     = 1'b0;
		b_v     = 1'b0;
		if (end_of_input) begin
			tok_a   = pend_tok;
			a_v     = pend_v;
			tok_b   = end_tok;
			b_v     = 1'b1;
			mode_nx = MODE_IDLE;
			wbuf_nx = '0;
			wlen_nx = '0;
			acc_nx  = '0;
		end else begin
			unique case (mode)
				MODE_HALTED: begin
					mode_nx = MODE_HALTED;
				end
				MODE_LOWER: begin
					if (is_low || is_up || is_dig) begin
						wbuf_nx = app_wbuf;
						wlen_nx = app_len;
					end else begin
						restart = 1'b1;
					end
				end
				MODE_UPPER: begin
					if (is_up) begin
						wbuf_nx = app_wbuf;
						wlen_nx = app_len;
					end else begin
						restart = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_dig) begin
						acc_nx = num_acc;
					end else begin
						restart = 1'b1;
					end
				end
				MODE_COLON: begin
					if (c == CHR_EQUAL) begin
						tok_a   = asg_tok;
						a_v     = 1'b1;
						mode_nx = MODE_IDLE;
						wbuf_nx = '0;
						wlen_nx = '0;
						acc_nx  = '0;
					end else begin
						restart = 1'b1;
					end
				end
				default: begin
					restart = 1'b1;
				end
			endcase
			// Flush the held token, then treat the character as fresh
			if (restart) begin
				tok_a   = pend_tok;
				a_v     = pend_v;
				tok_b   = idle_tok;
				b_v     = idle_v;
				mode_nx = idle_mode;
				wbuf_nx = idle_wbuf;
				wlen_nx = idle_len;
				acc_nx  = idle_acc;
			end
		end
	end

	// Pack tokens in order and mark the last one
	always_comb begin
		res = '0;
		if (a_v) begin
			res.t0 = tok_a;
			res.t1 = tok_b;
			if (b_v) begin
				res.n              = 2'd2;
				res.t1.last_of_run = 1'b1;
			end else begin
				res.n              = 2'd1;
				res.t0.last_of_run = 1'b1;
			end
		end else if (b_v) begin
			res.n              = 2'd1;
			res.t0             = tok_b;
			res.t0.last_of_run = 1'b1;
		end else begin
			res.n = 2'd0;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/kl_out_buf.sv -----
// kl_out_buf: two-entry token buffer between the scan step and the output.
// Depends on kl_pkg and keyword_lexer_unit_defines.svh.
`default_nettype none
`include "keyword_lexer_unit_defines.svh"

module kl_out_buf import kl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  step_res_t res,
	output logic      room,
	output logic      tok_valid,
	input  logic      tok_stall,
	output out_t      tok
);

	logic [1:0] cnt_q;
	out_t       slot0_q, slot1_q;
	logic       pop;

	// Head is always slot 0
	assign tok_valid = (cnt_q != 2'd0);
	assign tok       = slot0_q;
	assign pop       = tok_valid && !tok_stall;

	// A step may emit two tokens, so it needs the buffer empty after this pop
	assign room = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push) begin
			cnt_q <= res.n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Token slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot0_q <= res.t0;
			slot1_q <= res.t1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	`KL_NEVER(a_cnt_range, cnt_q == 2'd3, "token buffer count out of range")
	`KL_ASSERT(a_pair_order, (cnt_q == 2'd2) |-> (!slot0_q.last_of_run && slot1_q.last_of_run), "token pair marked out of order")
	`KL_ASSERT(a_push_room, push |-> room, "tokens pushed into a busy buffer")

endmodule

`default_nettype wire

// ----- hw/rtl/keyword_lexer_unit.sv -----
// Keyword lexer: one character per request, tokens out in order.
// A token passes through the input register and then the result buffer on its way to the output.
// Throughput: one character per cycle while each character yields at most one token
// and the output is not stalled; a character that yields two tokens holds the next
// until the two-entry buffer is empty or its last token is being popped.
// Reset (arst_n low, async) clears the scanner to idle and empties both stages.
// Depends on kl_pkg, kl_step, kl_out_buf and keyword_lexer_unit_defines.svh.
`default_nettype none
`include "keyword_lexer_unit_defines.svh"

module keyword_lexer_unit import kl_pkg::*; #(
	parameter int TEXT_BYTES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  in_t  req,
	output logic tok_valid,
	input  logic tok_stall,
	output out_t tok
);

	localparam int BW = 8 * TEXT_BYTES;

	logic        valid_s1;
	in_t         req_s1;
	logic        room, fire;
	mode_t       mode_q, mode_nx;
	logic [BW-1:0] wbuf_q, wbuf_nx;
	logic [3:0]  wlen_q, wlen_nx;
	logic [30:0] acc_q, acc_nx;
	step_res_t   step_res;

	// Input register: refills when empty or whenever the held request moves on
	assign fire      = valid_s1 && room;
	assign req_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// Scan step
	kl_step #(
		.TEXT_BYTES(TEXT_BYTES)
	) u_step (
		.mode        (mode_q),
		.wbuf        (wbuf_q),
		.wlen        (wlen_q),
		.acc         (acc_q),
		.char_code   (req_s1.char_code),
		.end_of_input(req_s1.end_of_input),
		.mode_nx     (mode_nx),
		.wbuf_nx     (wbuf_nx),
		.wlen_nx     (wlen_nx),
		.acc_nx      (acc_nx),
		.res         (step_res)
	);

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			wbuf_q <= '0;
			wlen_q <= '0;
			acc_q  <= '0;
		end else if (fire) begin
			mode_q <= mode_nx;
			wbuf_q <= wbuf_nx;
			wlen_q <= wlen_nx;
			acc_q  <= acc_nx;
		end
	end

	// Result buffer
	kl_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire),
		.res      (step_res),
		.room     (room),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok      (tok)
	);

	`KL_ASSERT(a_halt_silent, (fire && mode_q == MODE_HALTED && !req_s1.end_of_input) |-> (step_res.n == 2'd0), "halted scanner emitted a token")
	`KL_ASSERT(a_eoi_clears, (fire && req_s1.end_of_input) |=> (mode_q == MODE_IDLE && wlen_q == 4'd0), "end of input left scanner busy")
	`KL_NEVER(a_idle_clean, mode_q == MODE_IDLE && (wbuf_q != '0 || acc_q != '0), "idle scanner holds stale word state")

endmodule

`default_nettype wire
